[rtl/core/stid_pkg.sv]
package stid_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int KEY_W            = 32;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_DEL
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } t_cell_op;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op                  op;
        logic                      drop;
        logic signed [KEY_W-1:0]   key;
    } t_cell_ctl;

endpackage

[rtl/core/stid_cell.sv]
module stid_cell #(
    parameter int IDX          = 0,
    parameter int CNT_W        = 5,
    parameter int PAYLOAD_BITS = stid_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                              i_clk,
    input  stid_pkg::t_cell_ctl               i_ctl,
    input  logic [CNT_W-1:0]                  i_bound,
    input  logic [PAYLOAD_BITS-1:0]           i_new_pay,
    input  logic signed [stid_pkg::KEY_W-1:0] i_left_key,
    input  logic [PAYLOAD_BITS-1:0]           i_left_pay,
    input  logic                              i_left_gt,
    input  logic signed [stid_pkg::KEY_W-1:0] i_right_key,
    input  logic [PAYLOAD_BITS-1:0]           i_right_pay,
    input  logic signed [stid_pkg::KEY_W-1:0] i_head_key,
    input  logic [PAYLOAD_BITS-1:0]           i_head_pay,
    output logic signed [stid_pkg::KEY_W-1:0] o_key,
    output logic [PAYLOAD_BITS-1:0]           o_pay,
    output logic                              o_gt
);

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

    logic signed [stid_pkg::KEY_W-1:0] r_key, n_key;
    logic [PAYLOAD_BITS-1:0]           r_pay, n_pay;
    logic                              w_occ;
    logic                              w_gt;
    logic                              w_at_end;
    logic                              w_take_right;
    logic                              w_tail;

    assign w_occ        = IDX_C < i_bound;
    assign w_gt         = w_occ && (r_key > i_ctl.key);
    assign w_at_end     = IDX_C == i_bound;
    assign w_take_right = IDX_P1 < i_bound;
    assign w_tail       = IDX_P1 == i_bound;

    always_comb begin
        n_key = r_key;
        n_pay = r_pay;
        case (i_ctl.op)
            stid_pkg::CELL_INSERT: begin
                // larger keys move up one place; the first larger one takes the new record
                if (i_left_gt) begin
                    n_key = i_left_key;
                    n_pay = i_left_pay;
                end else if (w_gt || w_at_end) begin
                    n_key = i_ctl.key;
                    n_pay = i_new_pay;
                end
            end
            stid_pkg::CELL_ROTATE: begin
                // pop the head, push it back at the tail unless it is dropped
                if (w_take_right) begin
                    n_key = i_right_key;
                    n_pay = i_right_pay;
                end else if (w_tail && !i_ctl.drop) begin
                    n_key = i_head_key;
                    n_pay = i_head_pay;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pay <= n_pay;
    end

    assign o_key = r_key;
    assign o_pay = r_pay;
    assign o_gt  = w_gt;

endmodule

[rtl/core/sorted_table_insert_delete.sv]
// Flow: a request is taken in idle; an insert passes through the insert state, a delete
//   through the delete state, and the result strobe is registered from that state.
// Requests: busy stays high until the request is done, so no new one is taken before;
//   a delete walks every held record once through the head cell of the chain.
// Reset: synchronous, active low; empties the table and clears the strobe.
// The receiver cannot stall: each result shows for exactly one cycle.
module sorted_table_insert_delete #(
    parameter int CAPACITY     = stid_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = stid_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_req_type,
    input  logic signed [stid_pkg::KEY_W-1:0]   i_key,
    input  logic [PAYLOAD_BITS-1:0]             i_payload,
    output logic                                o_valid,
    output logic [stid_pkg::STATUS_W-1:0]       o_status,
    output logic [stid_pkg::COUNT_W-1:0]        o_count,
    output logic [PAYLOAD_BITS-1:0]             o_removed_payload
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Control state
    stid_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_valid, n_valid;

    // Request and delete-walk registers
    logic signed [stid_pkg::KEY_W-1:0] r_key, n_key;
    logic [PAYLOAD_BITS-1:0]           r_pay, n_pay;
    logic [CW-1:0]                     r_left, n_left;
    logic [CW-1:0]                     r_len, n_len;
    logic                              r_found, n_found;
    logic [PAYLOAD_BITS-1:0]           r_rem, n_rem;

    // Result registers
    stid_pkg::t_status                 r_status, n_status;
    logic [stid_pkg::COUNT_W-1:0]      r_out_count, n_out_count;
    logic [PAYLOAD_BITS-1:0]           r_removed, n_removed;

    // Chain wiring
    logic signed [stid_pkg::KEY_W-1:0] w_cell_key [CAPACITY];
    logic [PAYLOAD_BITS-1:0]           w_cell_pay [CAPACITY];
    logic                              w_cell_gt  [CAPACITY];
    stid_pkg::t_cell_ctl               w_ctl;
    logic [CW-1:0]                     w_bound;
    logic                              w_accept;
    logic                              w_full;
    logic                              w_walk;
    logic                              w_drop;
    logic                              w_last;

    assign busy     = r_state != stid_pkg::S_IDLE;
    assign w_accept = start && !busy;
    assign w_full   = r_count == CW'(CAPACITY);
    assign w_walk   = (r_state == stid_pkg::S_DEL) && (r_left != '0);
    // drop only the first matching record met at the head
    assign w_drop   = w_walk && !r_found && (w_cell_key[0] == r_key);
    assign w_last   = r_left <= CW'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stid_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = i_req_type ? stid_pkg::S_DEL : stid_pkg::S_INS;
                end
            end
            stid_pkg::S_INS: begin
                n_state = stid_pkg::S_IDLE;
            end
            stid_pkg::S_DEL: begin
                if (w_last) begin
                    n_state = stid_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stid_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb begin
        n_count     = r_count;
        n_valid     = 1'b0;
        n_key       = r_key;
        n_pay       = r_pay;
        n_left      = r_left;
        n_len       = r_len;
        n_found     = r_found;
        n_rem       = r_rem;
        n_status    = r_status;
        n_out_count = r_out_count;
        n_removed   = r_removed;
        w_ctl.op    = stid_pkg::CELL_HOLD;
        w_ctl.drop  = w_drop;
        w_ctl.key   = r_key;
        w_bound     = r_count;
        unique case (r_state)
            stid_pkg::S_IDLE: begin
                // latch the request and arm the walk over all held records
                if (w_accept) begin
                    n_key   = i_key;
                    n_pay   = i_payload;
                    n_left  = r_count;
                    n_len   = r_count;
                    n_found = 1'b0;
                    n_rem   = '0;
                end
            end
            stid_pkg::S_INS: begin
                n_valid   = 1'b1;
                n_removed = '0;
                if (w_full) begin
                    n_status    = stid_pkg::ST_FULL;
                    n_out_count = stid_pkg::COUNT_W'(r_count);
                end else begin
                    w_ctl.op    = stid_pkg::CELL_INSERT;
                    n_count     = r_count + CW'(1);
                    n_status    = stid_pkg::ST_DONE;
                    n_out_count = stid_pkg::COUNT_W'(r_count + CW'(1));
                end
            end
            stid_pkg::S_DEL: begin
                w_bound = r_len;
                if (w_walk) begin
                    w_ctl.op = stid_pkg::CELL_ROTATE;
                    n_left   = r_left - CW'(1);
                end
                if (w_drop) begin
                    n_len   = r_len - CW'(1);
                    n_found = 1'b1;
                    n_rem   = w_cell_pay[0];
                end
                if (w_last) begin
                    n_valid     = 1'b1;
                    n_count     = n_len;
                    n_out_count = stid_pkg::COUNT_W'(n_len);
                    n_removed   = n_rem;
                    n_status    = n_found ? stid_pkg::ST_DONE : stid_pkg::ST_NOTFOUND;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stid_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_pay       <= n_pay;
        r_left      <= n_left;
        r_len       <= n_len;
        r_found     <= n_found;
        r_rem       <= n_rem;
        r_status    <= n_status;
        r_out_count <= n_out_count;
        r_removed   <= n_removed;
    end

    // Chain of cells: cell 0 holds the smallest key
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [stid_pkg::KEY_W-1:0] w_lkey;
        logic [PAYLOAD_BITS-1:0]           w_lpay;
        logic                              w_lgt;
        logic signed [stid_pkg::KEY_W-1:0] w_rkey;
        logic [PAYLOAD_BITS-1:0]           w_rpay;

        if (g == 0) begin : g_first
            assign w_lkey = '0;
            assign w_lpay = '0;
            assign w_lgt  = 1'b0;
        end else begin : g_mid
            assign w_lkey = w_cell_key[g-1];
            assign w_lpay = w_cell_pay[g-1];
            assign w_lgt  = w_cell_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_rkey = w_cell_key[g];
            assign w_rpay = w_cell_pay[g];
        end else begin : g_inner
            assign w_rkey = w_cell_key[g+1];
            assign w_rpay = w_cell_pay[g+1];
        end

        stid_cell #(
            .IDX          (g),
            .CNT_W        (CW),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_bound     (w_bound),
            .i_new_pay   (r_pay),
            .i_left_key  (w_lkey),
            .i_left_pay  (w_lpay),
            .i_left_gt   (w_lgt),
            .i_right_key (w_rkey),
            .i_right_pay (w_rpay),
            .i_head_key  (w_cell_key[0]),
            .i_head_pay  (w_cell_pay[0]),
            .o_key       (w_cell_key[g]),
            .o_pay       (w_cell_pay[g]),
            .o_gt        (w_cell_gt[g])
        );
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_count           = r_out_count;
    assign o_removed_payload = r_removed;

endmodule

[tb/stid_tb_pkg.sv]
`timescale 1ns / 100ps

package stid_tb_pkg;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_DELETE = 1'b1
    } t_req;

    localparam logic signed [stid_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [stid_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

endpackage

[tb/sorted_table_insert_delete_checker.sv]
`timescale 1ns / 100ps

module sorted_table_insert_delete_checker #(
    parameter int CAPACITY     = stid_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = stid_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic                                i_req_type,
    input  logic signed [stid_pkg::KEY_W-1:0]   i_key,
    input  logic [PAYLOAD_BITS-1:0]             i_payload,
    input  logic                                i_valid,
    input  logic [stid_pkg::STATUS_W-1:0]       i_status,
    input  logic [stid_pkg::COUNT_W-1:0]        i_count,
    input  logic [PAYLOAD_BITS-1:0]             i_removed_payload,
    output int                                  o_fail_count,
    output int                                  o_outstanding
);
    import stid_pkg::*;
    import stid_tb_pkg::*;

    typedef struct {
        t_status                 status;
        logic [COUNT_W-1:0]      count;
        logic [PAYLOAD_BITS-1:0] removed;
    } t_reply;

    logic signed [KEY_W-1:0]  held_keys     [CAPACITY];
    logic [PAYLOAD_BITS-1:0]  held_payloads [CAPACITY];
    int                       held_count;
    t_reply                   replies_due [$];
    t_reply                   want;

    // Mirror one request on the table and return the reply it earns.
    function automatic t_reply apply_table_request(t_req req, logic signed [KEY_W-1:0] k,
                                                   logic [PAYLOAD_BITS-1:0] p);
        t_reply r;
        int     slot;
        int     hit;
        r.status  = ST_DONE;
        r.removed = '0;
        if (req == REQ_INSERT) begin
            if (held_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                slot = held_count;
                while (slot > 0 && held_keys[slot-1] > k) begin
                    held_keys[slot]     = held_keys[slot-1];
                    held_payloads[slot] = held_payloads[slot-1];
                    slot--;
                end
                held_keys[slot]     = k;
                held_payloads[slot] = p;
                held_count++;
            end
        end else begin
            hit = -1;
            for (int i = 0; i < held_count; i++)
                if (hit < 0 && held_keys[i] == k)
                    hit = i;
            if (hit < 0) begin
                r.status = ST_NOTFOUND;
            end else begin
                r.removed = held_payloads[hit];
                for (int i = hit; i + 1 < held_count; i++) begin
                    held_keys[i]     = held_keys[i+1];
                    held_payloads[i] = held_payloads[i+1];
                end
                held_count--;
            end
        end
        r.count = held_count[COUNT_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(string what);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    initial begin
        held_count    = 0;
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !i_busy)
                replies_due.push_back(apply_table_request(t_req'(i_req_type), i_key, i_payload));
            if (i_valid === 1'b1) begin
                if (replies_due.size() == 0) begin
                    note_mismatch("result strobe with no request outstanding");
                end else begin
                    want = replies_due.pop_front();
                    if (i_status !== want.status)
                        note_mismatch($sformatf("status expected %0d got %0d",
                                                want.status, i_status));
                    if (i_count !== want.count)
                        note_mismatch($sformatf("count expected %0d got %0d",
                                                want.count, i_count));
                    if (i_removed_payload !== want.removed)
                        note_mismatch($sformatf("removed payload expected %h got %h",
                                                want.removed, i_removed_payload));
                end
            end
        end
        o_outstanding <= replies_due.size();
    end

endmodule

[tb/sorted_table_insert_delete_test.sv]
`timescale 1ns / 100ps

module sorted_table_insert_delete_test;
    import stid_pkg::*;
    import stid_tb_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int PAYLOAD_BITS = PAYLOAD_BITS_DEF;
    localparam int RANDOM_ITEMS = 1600;
    // Tail of the run where the sender never pauses
    localparam int STEADY_TAIL  = 200;
    // Hang limit, set far above the slowest run of idle gaps and full-table deletes
    localparam int CYCLE_LIMIT  = 400000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_req_type;
    logic signed [KEY_W-1:0]   i_key;
    logic [PAYLOAD_BITS-1:0]   i_payload;
    logic                      o_valid;
    logic [STATUS_W-1:0]       o_status;
    logic [COUNT_W-1:0]        o_count;
    logic [PAYLOAD_BITS-1:0]   o_removed_payload;

    int fail_count;
    int outstanding;
    int cycle_count;

    sorted_table_insert_delete #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_key             (i_key),
        .i_payload         (i_payload),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_count           (o_count),
        .o_removed_payload (o_removed_payload)
    );

    // The checker watches both sides of the block, keeps its own copy of
    // the table and compares every result strobe in arrival order.
    sorted_table_insert_delete_checker #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_req_type        (i_req_type),
        .i_key             (i_key),
        .i_payload         (i_payload),
        .i_valid           (o_valid),
        .i_status          (o_status),
        .i_count           (o_count),
        .i_removed_payload (o_removed_payload),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Give up when the run hangs, e.g. when busy never drops or a strobe is lost.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Present one request from a falling edge and hold it until the rising edge
    // that takes it (start high, busy low). Return on the next falling edge so the
    // caller either presents the next request or drops start, never both.
    task automatic send_request(t_req req, logic signed [KEY_W-1:0] k,
                                logic [PAYLOAD_BITS-1:0] p);
        start      <= 1'b1;
        i_req_type <= req;
        i_key      <= k;
        i_payload  <= p;
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
    endtask

    // Drop start for a number of cycles; scramble the idle fields so nothing
    // depends on them while start is low.
    task automatic hold_off(int cycles);
        start      <= 1'b0;
        i_req_type <= t_req'($urandom_range(0, 1));
        i_key      <= $urandom;
        i_payload  <= {$urandom, $urandom};
        repeat (cycles) @(negedge i_clk);
    endtask

    // Draw a key mostly from a narrow pool so deletes hit held records and
    // equal keys pile up; sometimes draw any 32-bit key.
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 11))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(0, 8)) - 4;
        endcase
    endfunction

    function automatic logic [PAYLOAD_BITS-1:0] pick_payload();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int insert_pct;
        bit pauses_on;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req_type = REQ_INSERT;
        i_key      = '0;
        i_payload  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: delete from an empty table, then fill with extreme keys,
        // extreme payloads and repeated keys up to capacity.
        send_request(REQ_DELETE, 32'sd0, '1);
        send_request(REQ_INSERT, KEY_MAX, '1);
        send_request(REQ_INSERT, KEY_MIN, '0);
        send_request(REQ_INSERT, 32'sd0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(REQ_INSERT, -32'sd1, 64'h5555_5555_5555_5555);
        send_request(REQ_INSERT, 32'sd0, 64'h0123_4567_89AB_CDEF);
        send_request(REQ_INSERT, 32'sd1, 64'h8000_0000_0000_0001);
        send_request(REQ_INSERT, 32'sd0, 64'hFEDC_BA98_7654_3210);
        send_request(REQ_INSERT, KEY_MAX, 64'h0000_0000_FFFF_FFFF);
        send_request(REQ_INSERT, KEY_MIN, 64'hFFFF_FFFF_0000_0000);
        for (int i = 0; i < CAPACITY - 9; i++)
            send_request(REQ_INSERT, pick_key(), pick_payload());
        // Table is full now: the insert is dropped, a missing key is reported.
        send_request(REQ_INSERT, 32'sd3, '1);
        send_request(REQ_DELETE, 32'sd12345, '1);
        // Equal keys leave in arrival order; hit both ends of the key range.
        send_request(REQ_DELETE, 32'sd0, '0);
        send_request(REQ_DELETE, KEY_MIN, '0);
        send_request(REQ_DELETE, KEY_MAX, '0);
        send_request(REQ_DELETE, -32'sd1, '0);

        // Random: switch between fill-leaning, drain-leaning and balanced
        // stretches so the table swings between empty and full.
        insert_pct = 50;
        pauses_on  = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 80;
                    1:       insert_pct = 25;
                    default: insert_pct = 50;
                endcase
                pauses_on = ($urandom_range(0, 3) != 0);
            end
            if (pauses_on && n < RANDOM_ITEMS - STEADY_TAIL && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 14));
            if ($urandom_range(1, 100) <= insert_pct)
                send_request(REQ_INSERT, pick_key(), pick_payload());
            else
                send_request(REQ_DELETE, pick_key(), pick_payload());
        end
        start <= 1'b0;

        // Drain: wait for every result, then wait on for stray strobes.
        wait (outstanding == 0);
        repeat (2 * CAPACITY + 4) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
